// ----- sv/idxl_pkg.sv -----
// idxl_pkg: shared codes, widths and types for the indexed insert/remove list.
// No dependencies; used by idxl_ctrl, idxl_cell and indexed_insert_remove_list_core.
package idxl_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int MODE_W        = 3;
  localparam int POS_W         = 5;
  localparam int DATA_W        = 32;
  localparam int COUNT_W       = 5;

  localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PREPEND = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd5;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_WR   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic signed [DATA_W-1:0] wdata;
  } cell_ctl_t;

endpackage

// ----- sv/idxl_ctrl.sv -----
// idxl_ctrl: decodes one transaction, checks the index against the entry count,
// keeps the count register and broadcasts the shift/write command to the cells.
// Depends on idxl_pkg.
module idxl_ctrl #(
  parameter int DEPTH = idxl_pkg::DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  logic [idxl_pkg::MODE_W-1:0]       mode,
  input  logic [idxl_pkg::POS_W-1:0]        position,
  input  logic signed [idxl_pkg::DATA_W-1:0] value,
  output idxl_pkg::cell_ctl_t               ctl,
  output logic [CW-1:0]                     at,
  output logic                              ok,
  output logic                              is_read,
  output logic [CW-1:0]                     count_r,
  output logic [CW-1:0]                     count_nxt
);

  localparam int CMPW = (CW > idxl_pkg::POS_W) ? CW : idxl_pkg::POS_W;

  logic [CMPW-1:0]     pos_ext;
  logic [CMPW-1:0]     cnt_ext;
  logic                full;
  logic                pos_lt;
  logic                pos_le;
  idxl_pkg::cell_op_t  op;

  assign pos_ext = CMPW'(position);
  assign cnt_ext = CMPW'(count_r);
  assign full    = (count_r == CW'(DEPTH));
  assign pos_lt  = (pos_ext < cnt_ext);
  assign pos_le  = (pos_ext <= cnt_ext);
  assign is_read = (mode == idxl_pkg::MODE_READ);

  always_comb begin
    ok = 1'b0;
    op = idxl_pkg::CELL_HOLD;
    at = CW'(pos_ext);
    unique case (mode)
      idxl_pkg::MODE_APPEND: begin
        ok = !full;
        op = idxl_pkg::CELL_INS;
        at = count_r;
      end
      idxl_pkg::MODE_PREPEND: begin
        ok = !full;
        op = idxl_pkg::CELL_INS;
        at = '0;
      end
      idxl_pkg::MODE_INSERT: begin
        ok = !full && pos_le;
        op = idxl_pkg::CELL_INS;
      end
      idxl_pkg::MODE_REMOVE: begin
        ok = pos_lt;
        op = idxl_pkg::CELL_DEL;
      end
      idxl_pkg::MODE_REPLACE: begin
        ok = pos_lt;
        op = idxl_pkg::CELL_WR;
      end
      idxl_pkg::MODE_READ: begin
        ok = pos_lt;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctl.wdata = value;
    ctl.op    = (fire && ok) ? op : idxl_pkg::CELL_HOLD;
    count_nxt = count_r;
    case (ctl.op)
      idxl_pkg::CELL_INS: count_nxt = count_r + CW'(1);
      idxl_pkg::CELL_DEL: count_nxt = count_r - CW'(1);
      default:            count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ----- sv/idxl_cell.sv -----
// idxl_cell: one list slot; takes its left neighbor on insert, its right
// neighbor on remove, the broadcast value on a direct write. Depends on idxl_pkg.
module idxl_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  idxl_pkg::cell_ctl_t                ctl,
  input  logic [CW-1:0]                      at,
  input  logic signed [idxl_pkg::DATA_W-1:0] left_data,
  input  logic signed [idxl_pkg::DATA_W-1:0] right_data,
  output logic signed [idxl_pkg::DATA_W-1:0] data_r,
  output logic signed [idxl_pkg::DATA_W-1:0] rd_data
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic signed [idxl_pkg::DATA_W-1:0] data_nxt;
  logic                               hit;
  logic                               above;

  assign hit     = (at == MY_IDX);
  assign above   = (MY_IDX > at);
  assign rd_data = hit ? data_r : '0;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      idxl_pkg::CELL_INS: begin
        if (hit) begin
          data_nxt = ctl.wdata;
        end else if (above) begin
          data_nxt = left_data;
        end
      end
      idxl_pkg::CELL_DEL: begin
        if (hit || above) begin
          data_nxt = right_data;
        end
      end
      idxl_pkg::CELL_WR: begin
        if (hit) begin
          data_nxt = ctl.wdata;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ----- sv/indexed_insert_remove_list_core.sv -----
// indexed_insert_remove_list_core: top level of the indexed insert/remove list.
// Depends on idxl_pkg, idxl_ctrl and idxl_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per transaction:
//   in_mode (append, prepend, insert, remove, replace, read), in_position and
//   in_value. Result channel (out_valid/out_ready) returns one transaction per
//   operation: out_read_value (zero unless a read in range), out_count (entries
//   after the operation) and out_accepted (0 on a bad index, full list or
//   unknown mode).
//   Latency: the result is valid the cycle after the operation is accepted.
//   Throughput: one operation per cycle while out_ready takes each result. All DEPTH
//   cells shift or load in parallel in the accept cycle.
//   Stall: the result sits in an output register; in_ready is low only while
//   that register holds an untaken result, and rises in the cycle out_ready
//   takes it, so a new operation can be accepted in that same cycle.
//   Reset: synchronous, active low; clears the entry count and the output
//   valid. Slot contents are not cleared; slots at or above the count are
//   never read.
module indexed_insert_remove_list_core #(
  parameter int DEPTH = idxl_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [idxl_pkg::MODE_W-1:0]        in_mode,
  input  logic [idxl_pkg::POS_W-1:0]         in_position,
  input  logic signed [idxl_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [idxl_pkg::DATA_W-1:0] out_read_value,
  output logic [idxl_pkg::COUNT_W-1:0]       out_count,
  output logic                               out_accepted
);

  localparam int CW = $clog2(DEPTH + 1);

  logic                               in_fire;
  idxl_pkg::cell_ctl_t                ctl;
  logic [CW-1:0]                      at;
  logic                               ok;
  logic                               is_read;
  logic [CW-1:0]                      count_r;
  logic [CW-1:0]                      count_nxt;
  logic signed [idxl_pkg::DATA_W-1:0] cell_data [DEPTH];
  logic signed [idxl_pkg::DATA_W-1:0] cell_rd   [DEPTH];
  logic signed [idxl_pkg::DATA_W-1:0] rd_bus;

  logic                               out_valid_r;
  logic signed [idxl_pkg::DATA_W-1:0] out_read_value_r;
  logic [idxl_pkg::COUNT_W-1:0]       out_count_r;
  logic                               out_accepted_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  idxl_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .mode      (in_mode),
    .position  (in_position),
    .value     (in_value),
    .ctl       (ctl),
    .at        (at),
    .ok        (ok),
    .is_read   (is_read),
    .count_r   (count_r),
    .count_nxt (count_nxt)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    idxl_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .at         (at),
      .left_data  ((g == 0) ? cell_data[0] : cell_data[(g == 0) ? 0 : g - 1]),
      .right_data (cell_data[(g == DEPTH - 1) ? g : g + 1]),
      .data_r     (cell_data[g]),
      .rd_data    (cell_rd[g])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_read_value_r <= (ok && is_read) ? rd_bus : '0;
      out_count_r      <= idxl_pkg::COUNT_W'(count_nxt);
      out_accepted_r   <= ok;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;
  assign out_accepted   = out_accepted_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_refused_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !ok |=> count_r == $past(count_r))
    else $error("refused operation changed the count");

  a_read_value_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_read_value_r != '0 |-> out_accepted_r)
    else $error("nonzero read value on a refused operation");
`endif

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for indexed_insert_remove_list_core: directed table, then random phases.
// Depends on idxl_pkg and the core; results are checked against typed rows or a list predictor.
module testbench;

  localparam int LIST_DEPTH   = idxl_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 800;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SHOW_LIMIT   = 10;
  localparam logic [idxl_pkg::MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [idxl_pkg::MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic signed [idxl_pkg::DATA_W-1:0] rd;
    logic [idxl_pkg::COUNT_W-1:0]       cnt;
    logic                               ok;
  } list_res_t;

  typedef struct {
    logic [idxl_pkg::MODE_W-1:0]        mode;
    logic [idxl_pkg::POS_W-1:0]         pos;
    logic signed [idxl_pkg::DATA_W-1:0] val;
    int                                 reps;
    bit                                 typed;
    list_res_t                          exp;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [idxl_pkg::MODE_W-1:0] in_mode = '0;
  logic [idxl_pkg::POS_W-1:0] in_position = '0;
  logic signed [idxl_pkg::DATA_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [idxl_pkg::DATA_W-1:0] out_read_value;
  logic [idxl_pkg::COUNT_W-1:0] out_count;
  logic out_accepted;

  // typed expectation riding along with the transaction on the input port
  bit cur_typed = 1'b0;
  list_res_t cur_exp = '0;

  logic signed [idxl_pkg::DATA_W-1:0] list_mem [LIST_DEPTH];
  int list_len = 0;
  list_res_t pending_results[$];
  op_row_t dir_rows[$];

  bit quiet = 1'b0;
  int n_fail = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_refused = 0;
  int n_full_hits = 0;
  int idle_cycles = 0;

  indexed_insert_remove_list_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_position(in_position), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_value(out_read_value), .out_count(out_count), .out_accepted(out_accepted)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit list_open(input int at,
                                   input logic signed [idxl_pkg::DATA_W-1:0] v);
    if (list_len >= LIST_DEPTH || at > list_len) return 1'b0;
    for (int i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
    list_mem[at] = v;
    list_len++;
    return 1'b1;
  endfunction

  function automatic list_res_t list_step(input logic [idxl_pkg::MODE_W-1:0] op,
                                          input logic [idxl_pkg::POS_W-1:0] at,
                                          input logic signed [idxl_pkg::DATA_W-1:0] v);
    list_res_t r;
    int idx;
    r = '0;
    idx = int'(at);
    case (op)
      idxl_pkg::MODE_APPEND:  r.ok = list_open(list_len, v);
      idxl_pkg::MODE_PREPEND: r.ok = list_open(0, v);
      idxl_pkg::MODE_INSERT:  r.ok = list_open(idx, v);
      idxl_pkg::MODE_REMOVE: begin
        if (idx < list_len) begin
          for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      idxl_pkg::MODE_REPLACE: begin
        if (idx < list_len) begin
          list_mem[idx] = v;
          r.ok = 1'b1;
        end
      end
      idxl_pkg::MODE_READ: begin
        if (idx < list_len) begin
          r.rd = list_mem[idx];
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.cnt = idxl_pkg::COUNT_W'(list_len);
    return r;
  endfunction

  function automatic void add_row(input logic [idxl_pkg::MODE_W-1:0] m, input int p,
                                  input logic signed [idxl_pkg::DATA_W-1:0] v,
                                  input int reps, input bit typed,
                                  input logic signed [idxl_pkg::DATA_W-1:0] rd,
                                  input int cnt, input bit ok);
    op_row_t row;
    row.mode = m;
    row.pos = idxl_pkg::POS_W'(p);
    row.val = v;
    row.reps = reps;
    row.typed = typed;
    row.exp.rd = rd;
    row.exp.cnt = idxl_pkg::COUNT_W'(cnt);
    row.exp.ok = ok;
    dir_rows.push_back(row);
  endfunction

  task automatic send_op(input logic [idxl_pkg::MODE_W-1:0] m,
                         input logic [idxl_pkg::POS_W-1:0] p,
                         input logic signed [idxl_pkg::DATA_W-1:0] v, input bit typed,
                         input list_res_t exp);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_mode <= m;
    in_position <= p;
    in_value <= v;
    cur_typed <= typed;
    cur_exp <= exp;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    n_sent++;
  endtask

  always @(posedge clk) begin : monitor
    list_res_t got;
    list_res_t want;
    list_res_t pred;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        got.rd = out_read_value;
        got.cnt = out_count;
        got.ok = out_accepted;
        if (pending_results.size() == 0) begin
          n_fail++;
          if (n_fail <= SHOW_LIMIT)
            $display("unexpected result: rd=%0d count=%0d ok=%0b", got.rd, got.cnt, got.ok);
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (got !== want) begin
            n_fail++;
            if (n_fail <= SHOW_LIMIT)
              $display({"mismatch on result %0d: expected rd=%0d count=%0d ok=%0b,",
                        " got rd=%0d count=%0d ok=%0b"},
                       n_checked, want.rd, want.cnt, want.ok, got.rd, got.cnt, got.ok);
          end
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        if (list_len == LIST_DEPTH &&
            (in_mode == idxl_pkg::MODE_APPEND || in_mode == idxl_pkg::MODE_PREPEND ||
             in_mode == idxl_pkg::MODE_INSERT))
          n_full_hits++;
        pred = list_step(in_mode, in_position, in_value);
        if (!pred.ok) n_refused++;
        pending_results.push_back(cur_typed ? cur_exp : pred);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : stim
    op_row_t row;
    list_res_t none;
    int n_dir;
    int n_random;
    int kind;
    int plen;
    int r;
    int hi;
    logic [idxl_pkg::MODE_W-1:0] m;
    logic [idxl_pkg::POS_W-1:0] p;
    logic signed [idxl_pkg::DATA_W-1:0] v;

    none = '0;
    n_random = 0;
    // empty list: everything indexed is out of range
    add_row(idxl_pkg::MODE_READ,    0,  32'sd5,  1, 1, 0, 0, 0);
    add_row(idxl_pkg::MODE_REMOVE,  0,  32'sd0,  1, 1, 0, 0, 0);
    add_row(idxl_pkg::MODE_REPLACE, 0,  32'sd7,  1, 1, 0, 0, 0);
    add_row(idxl_pkg::MODE_INSERT,  1,  32'sd9,  1, 1, 0, 0, 0);
    add_row(MODE_UNUSED_6,          0,  -32'sd1, 1, 1, 0, 0, 0);
    add_row(MODE_UNUSED_7,          31, -32'sd1, 1, 1, 0, 0, 0);
    // build [min, 0x1234, max, -1]
    add_row(idxl_pkg::MODE_APPEND,  0,  32'sh7fffffff, 1, 1, 0, 1, 1);
    add_row(idxl_pkg::MODE_PREPEND, 0,  32'sh80000000, 1, 1, 0, 2, 1);
    add_row(idxl_pkg::MODE_INSERT,  2,  -32'sd1,       1, 1, 0, 3, 1);
    add_row(idxl_pkg::MODE_INSERT,  1,  32'sh1234,     1, 0, 0, 0, 0);
    add_row(idxl_pkg::MODE_READ,    0,  32'sd0,        1, 1, 32'sh80000000, 4, 1);
    add_row(idxl_pkg::MODE_READ,    3,  32'sd0,        1, 0, 0, 0, 0);
    // fill to capacity, then hit the full list
    add_row(idxl_pkg::MODE_APPEND,  0,  32'sd0,  12, 0, 0, 0, 0);
    add_row(idxl_pkg::MODE_APPEND,  0,  32'sd1,  1, 1, 0, 16, 0);
    add_row(idxl_pkg::MODE_PREPEND, 0,  32'sd1,  1, 1, 0, 16, 0);
    add_row(idxl_pkg::MODE_INSERT,  16, 32'sd1,  1, 1, 0, 16, 0);
    add_row(idxl_pkg::MODE_READ,    16, 32'sd0,  1, 1, 0, 16, 0);
    add_row(idxl_pkg::MODE_REPLACE, 15, 32'sh55aa55aa, 1, 0, 0, 0, 0);
    add_row(idxl_pkg::MODE_READ,    15, 32'sd0,  1, 0, 0, 0, 0);
    add_row(idxl_pkg::MODE_REMOVE,  15, 32'sd0,  1, 1, 0, 15, 1);
    add_row(idxl_pkg::MODE_REMOVE,  0,  32'sd0,  1, 0, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      for (int k = 0; k < row.reps; k++)
        send_op(row.mode, row.pos, (row.reps > 1) ? $signed($urandom) : row.val,
                row.typed, row.exp);
    end
    n_dir = n_sent;

    // phases: 0 grows the list, 1 shrinks it, 2 mixes all operations
    while (n_random < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 2);
      plen = $urandom_range(10, 60);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (plen) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          m = (r == 0) ? MODE_UNUSED_6 : MODE_UNUSED_7;
        end else begin
          case (kind)
            0: m = (r < 40) ? idxl_pkg::MODE_APPEND :
                   (r < 60) ? idxl_pkg::MODE_PREPEND :
                   (r < 88) ? idxl_pkg::MODE_INSERT :
                   idxl_pkg::MODE_W'($urandom_range(3, 5));
            1: m = (r < 60) ? idxl_pkg::MODE_REMOVE :
                   (r < 85) ? idxl_pkg::MODE_READ :
                   idxl_pkg::MODE_W'($urandom_range(0, 4));
            default: m = idxl_pkg::MODE_W'($urandom_range(0, 5));
          endcase
        end
        hi = (m == idxl_pkg::MODE_INSERT) ? list_len
                                          : ((list_len > 0) ? list_len - 1 : 0);
        p = ($urandom_range(0, 9) == 0) ? idxl_pkg::POS_W'($urandom_range(0, 31))
                                        : idxl_pkg::POS_W'($urandom_range(0, hi));
        case ($urandom_range(0, 7))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = '0;
          3: v = -32'sd1;
          default: v = $signed($urandom);
        endcase
        send_op(m, p, v, 1'b0, none);
        n_random++;
      end
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);

    $display("%0d operations (%0d directed), %0d results checked", n_sent, n_dir, n_checked);
    $display("%0d operations refused, %0d adds against a full list", n_refused, n_full_hits);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures", n_fail);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
